>>> hw/rtl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
// No dependencies; used by first_fit_block_allocator_top.
package ffba_pkg;

  // Request kinds (s_tuser)
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes (m_tuser)
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Field widths fixed by the interface
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CNT_OUT_W = 7;

  // One block table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] bytes;
    logic              is_free;
  } entry_t;

endpackage

>>> hw/rtl/first_fit_block_allocator_top.sv
// First-fit heap block allocator: block table in one synchronous RAM,
// scanned one entry per cycle. Depends on ffba_pkg.
//
// Usage:
//  - s_* channel takes one request word: s_tuser is the kind (0 allocate,
//    1 free), s_tdata carries size and address. A request is taken when
//    s_tvalid and s_tready are both high.
//  - m_* channel returns one result word per request: m_tuser is the status,
//    m_tdata carries the address and the usage figures after the step.
//  - cfg_wen/cfg_wdata write heap_start, which sets the bump pointer.
//    Write only while no request is in flight. The block table is kept.
// Operation: a request is scanned from entry 0 up to the first match or the
// last entry; a null free or an empty table skips the scan. The scan does
// one RAM read per entry, with a registered read, and is followed by an
// update step that writes back the chosen entry and the usage counters.
// One request is in work at a time. The result sits in an output register,
// so the next request is taken while it waits; if the receiver stalls, the
// update cycle of that next request waits until the output register frees.
// Reset (rst, synchronous) empties the table, clears the bump pointer and
// counters and drops any pending result. RAM contents are not cleared; only
// entries below the block count are ever checked.
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Config: heap_start
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] req_size, [63:32] req_addr
  input  logic [0:0]  s_tuser,   // [0] req_type
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] result_addr, [63:32] used_bytes,
                                 // [70:64] used_blocks, [77:71] free_blocks
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW = ffba_pkg::ADDR_W + CW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state;

  // Request registers
  logic        req_type;
  logic [31:0] req_size;
  logic [31:0] req_addr;

  // Allocator state
  logic [CW-1:0] block_count;
  logic [31:0]   bump_pointer;
  logic [SW-1:0] used_sum;
  logic [CW-1:0] nused;
  logic [CW-1:0] nfree;

  // Scan pipeline
  logic [IW-1:0] issue_idx;
  logic          chk_vld;
  logic          chk_last;
  logic [IW-1:0] chk_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  ffba_pkg::entry_t hit_entry;

  // Block table RAM
  ffba_pkg::entry_t mem [MAX_BLOCKS];
  ffba_pkg::entry_t rd_entry;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  ffba_pkg::entry_t mem_wdata;

  // Update-cycle results
  logic          proceed;
  logic [1:0]    status_next;
  logic [31:0]   res_addr_next;
  logic [SW-1:0] used_sum_next;
  logic [CW-1:0] nused_next;
  logic [CW-1:0] nfree_next;
  logic [CW-1:0] block_count_next;
  logic [31:0]   bump_pointer_next;
  logic [32:0]   bump_end;
  logic          match;
  logic          table_full;

  assign s_tready = (state == S_IDLE);

  // Table RAM: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[issue_idx];
  end

  // Match test on the entry just read
  always_comb begin
    if (req_type == ffba_pkg::REQ_ALLOC) begin
      match = rd_entry.is_free && (rd_entry.bytes >= req_size);
    end else begin
      match = !rd_entry.is_free && (rd_entry.addr == req_addr);
    end
  end

  assign proceed    = !m_tvalid || m_tready;
  assign table_full = (block_count == CW'(MAX_BLOCKS));
  assign bump_end   = {1'b0, bump_pointer} + {1'b0, req_size};

  // Work out the write-back and the new counters
  always_comb begin
    mem_we            = 1'b0;
    mem_waddr         = hit_idx;
    mem_wdata         = hit_entry;
    status_next       = ffba_pkg::ST_OK;
    res_addr_next     = '0;
    used_sum_next     = used_sum;
    nused_next        = nused;
    nfree_next        = nfree;
    block_count_next  = block_count;
    bump_pointer_next = bump_pointer;
    if (req_type == ffba_pkg::REQ_ALLOC) begin
      if (hit) begin
        mem_we            = 1'b1;
        mem_wdata.is_free = 1'b0;
        res_addr_next     = hit_entry.addr;
        used_sum_next     = used_sum + SW'(hit_entry.bytes);
        nused_next        = nused + CW'(1);
        nfree_next        = nfree - CW'(1);
      end else if (table_full) begin
        status_next = ffba_pkg::ST_FULL;
      end else if (bump_end[32]) begin
        status_next = ffba_pkg::ST_OVERFLOW;
      end else begin
        mem_we            = 1'b1;
        mem_waddr         = block_count[IW-1:0];
        mem_wdata.addr    = bump_pointer;
        mem_wdata.bytes   = req_size;
        mem_wdata.is_free = 1'b0;
        res_addr_next     = bump_pointer;
        used_sum_next     = used_sum + SW'(req_size);
        nused_next        = nused + CW'(1);
        block_count_next  = block_count + CW'(1);
        bump_pointer_next = bump_end[31:0];
      end
    end else begin
      if (hit) begin
        mem_we            = 1'b1;
        mem_wdata.is_free = 1'b1;
        used_sum_next     = used_sum - SW'(hit_entry.bytes);
        nused_next        = nused - CW'(1);
        nfree_next        = nfree + CW'(1);
      end else begin
        status_next = ffba_pkg::ST_NOT_FOUND;
      end
    end
    if ((state != S_UPDATE) || !proceed) begin
      mem_we = 1'b0;
    end
  end

  // Bump pointer: heap start write sets it, an append advances it
  always_ff @(posedge clk) begin
    if (rst) begin
      bump_pointer <= '0;
    end else if (cfg_wen) begin
      bump_pointer <= cfg_wdata;
    end else if ((state == S_UPDATE) && proceed) begin
      bump_pointer <= bump_pointer_next;
    end
  end

  // Sequencer: accept, scan, update
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      block_count  <= '0;
      used_sum     <= '0;
      nused        <= '0;
      nfree        <= '0;
      chk_vld      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // Drop the result once taken
      if (m_tvalid && m_tready && (state != S_UPDATE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          issue_idx <= '0;
          chk_vld   <= 1'b0;
          if (s_tvalid) begin
            req_type <= s_tuser[0];
            req_size <= s_tdata[31:0];
            req_addr <= s_tdata[63:32];
            if (((s_tuser[0] == ffba_pkg::REQ_FREE) && (s_tdata[63:32] == '0)) ||
                (block_count == '0)) begin
              hit   <= 1'b0;
              state <= S_UPDATE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue the next read, check the one that came back
          issue_idx <= issue_idx + IW'(1);
          chk_idx   <= issue_idx;
          chk_last  <= (CW'(issue_idx) == block_count - CW'(1));
          if (chk_vld && (match || chk_last)) begin
            hit       <= match;
            hit_idx   <= chk_idx;
            hit_entry <= rd_entry;
            chk_vld   <= 1'b0;
            state     <= S_UPDATE;
          end else begin
            chk_vld   <= 1'b1;
          end
        end
        S_UPDATE: begin
          if (proceed) begin
            block_count  <= block_count_next;
            used_sum     <= used_sum_next;
            nused        <= nused_next;
            nfree        <= nfree_next;
            m_tvalid     <= 1'b1;
            m_tuser      <= status_next;
            m_tdata[31:0]  <= res_addr_next;
            m_tdata[63:32] <= (|used_sum_next[SW-1:32]) ? 32'hFFFF_FFFF
                                                        : used_sum_next[31:0];
            m_tdata[70:64] <= ffba_pkg::CNT_OUT_W'(nused_next);
            m_tdata[77:71] <= ffba_pkg::CNT_OUT_W'(nfree_next);
            m_tdata[79:78] <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    block_count <= CW'(MAX_BLOCKS))
    else $error("block count beyond table size");

  a_count_split: assert property (@(posedge clk) disable iff (rst)
    (nused + nfree) == block_count)
    else $error("busy and free counts do not add up to block count");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_UPDATE) && (!m_tvalid || m_tready))
    else $error("table written outside a free update cycle");

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) && proceed |=> m_tvalid && (state == S_IDLE))
    else $error("update did not produce a result");

endmodule

>>> test/testbench.sv
// Self-checking testbench for first_fit_block_allocator_top: directed table, then random
// allocate/free traffic, each result word checked against a local heap table predictor
// or, for typed rows, a fixed expectation. Depends on ffba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int TBL_DEPTH    = 64;
  localparam int DRAIN_CYCLES = TBL_DEPTH + 16;
  localparam int PHASES       = 16;
  localparam int PHASE_WORDS  = 98;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [31:0] used_bytes;
    logic [6:0]  used_blocks;
    logic [6:0]  free_blocks;
  } alloc_result_t;

  typedef enum bit {ROW_REQUEST, ROW_HEAP_START} row_kind_e;

  // One directed row; a heap_start row carries its value in addr
  typedef struct packed {
    row_kind_e     kind;
    logic          req_type;
    logic [31:0]   size;
    logic [31:0]   addr;
    bit            typed;
    alloc_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [31:0] req_size, [63:32] req_addr
  logic [0:0]  s_tuser;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // [31:0] result_addr, [63:32] used_bytes,
                          // [70:64] used_blocks, [77:71] free_blocks
  logic [1:0]  m_tuser;   // [1:0] status

  // Predicted heap table
  logic [31:0] blk_addr  [TBL_DEPTH];
  logic [31:0] blk_bytes [TBL_DEPTH];
  bit          blk_free  [TBL_DEPTH];
  int unsigned blk_count;
  logic [31:0] bump_ptr;

  alloc_result_t expected_results[$];
  stim_row_t     dir_rows[$];
  int            mismatch_count;
  bit            calm;

  first_fit_block_allocator_top #(
    .MAX_BLOCKS(TBL_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run one request through the predicted table and report usage after it
  function automatic alloc_result_t heap_model_step(logic req_type, logic [31:0] size,
                                                    logic [31:0] addr);
    alloc_result_t r;
    bit            done;
    logic [32:0]   sum;
    logic [6:0]    nused;
    logic [6:0]    nfree;
    int unsigned   i;
    r = '0;
    done = 1'b0;
    if (req_type == ffba_pkg::REQ_ALLOC) begin
      // First fit among recorded free blocks
      for (i = 0; i < blk_count && !done; i++) begin
        if (blk_free[i] && blk_bytes[i] >= size) begin
          blk_free[i] = 1'b0;
          r.addr = blk_addr[i];
          r.status = ffba_pkg::ST_OK;
          done = 1'b1;
        end
      end
      // Otherwise append at the bump pointer
      if (!done) begin
        if (blk_count >= TBL_DEPTH) begin
          r.status = ffba_pkg::ST_FULL;
        end else if ({1'b0, bump_ptr} + {1'b0, size} > 33'h0_FFFF_FFFF) begin
          r.status = ffba_pkg::ST_OVERFLOW;
        end else begin
          blk_addr[blk_count] = bump_ptr;
          blk_bytes[blk_count] = size;
          blk_free[blk_count] = 1'b0;
          blk_count++;
          r.addr = bump_ptr;
          r.status = ffba_pkg::ST_OK;
          bump_ptr = bump_ptr + size;
        end
      end
    end else begin
      r.status = ffba_pkg::ST_NOT_FOUND;
      if (addr != 32'd0) begin
        for (i = 0; i < blk_count && !done; i++) begin
          if (!blk_free[i] && blk_addr[i] == addr) begin
            blk_free[i] = 1'b1;
            r.status = ffba_pkg::ST_OK;
            done = 1'b1;
          end
        end
      end
    end
    // Usage totals, bytes saturate at 32 bits
    sum = '0;
    nused = '0;
    nfree = '0;
    for (i = 0; i < blk_count; i++) begin
      if (blk_free[i]) begin
        nfree++;
      end else begin
        nused++;
        sum = sum + {1'b0, blk_bytes[i]};
        if (sum[32]) sum = 33'h0_FFFF_FFFF;
      end
    end
    r.used_bytes = sum[31:0];
    r.used_blocks = nused;
    r.free_blocks = nfree;
    return r;
  endfunction

  function automatic stim_row_t ask(logic req_type, logic [31:0] size, logic [31:0] addr);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req_type = req_type;
    row.size = size;
    row.addr = addr;
    return row;
  endfunction

  function automatic stim_row_t ask_typed(logic req_type, logic [31:0] size, logic [31:0] addr,
                                          logic [31:0] e_addr, logic [1:0] e_status,
                                          logic [31:0] e_used, logic [6:0] e_nused,
                                          logic [6:0] e_nfree);
    stim_row_t row;
    row = ask(req_type, size, addr);
    row.typed = 1'b1;
    row.want = '{e_addr, e_status, e_used, e_nused, e_nfree};
    return row;
  endfunction

  function automatic stim_row_t heap_row(logic [31:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_HEAP_START;
    row.addr = value;
    return row;
  endfunction

  // Present one request word, hold it until taken, then queue its expected result
  task automatic put_word(logic req_type, logic [31:0] size, logic [31:0] addr, bit typed,
                          alloc_result_t want);
    alloc_result_t predicted;
    s_tvalid <= 1'b1;
    s_tuser <= req_type;
    s_tdata <= {addr, size};
    do @(posedge clk); while (!s_tready);
    predicted = heap_model_step(req_type, size, addr);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Drain all results, then write heap_start while the block is idle
  task automatic write_heap_start(logic [31:0] value);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    bump_ptr = value;
  endtask

  // Mostly well-formed traffic: small allocates and frees of live blocks, some noise
  task automatic random_word();
    logic [31:0] size;
    logic [31:0] addr;
    logic        req_type;
    int          busy[$];
    int          pick;
    int          i;
    req_type = ($urandom_range(0, 1) != 0);
    size = $urandom;
    addr = $urandom;
    pick = $urandom_range(0, 9);
    if (req_type == ffba_pkg::REQ_ALLOC) begin
      if (pick == 0) size = 32'd0;
      else if (pick >= 3) size = $urandom_range(1, 1024);
    end else begin
      if (pick == 0) begin
        addr = 32'd0;
      end else if (pick >= 3) begin
        for (i = 0; i < int'(blk_count); i++) begin
          if (!blk_free[i]) busy.push_back(i);
        end
        if (busy.size() != 0) addr = blk_addr[busy[$urandom_range(0, busy.size() - 1)]];
      end
    end
    maybe_pause();
    put_word(req_type, size, addr, 1'b0, '0);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Check every accepted result word against the oldest expectation
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word: expected none, got addr %h status %0d",
                 $time, m_tdata[31:0], m_tuser);
      end else begin
        want = expected_results.pop_front();
        compare_field("result_addr", want.addr, m_tdata[31:0]);
        compare_field("status", 32'(want.status), 32'(m_tuser));
        compare_field("used_bytes", want.used_bytes, m_tdata[63:32]);
        compare_field("used_blocks", 32'(want.used_blocks), 32'(m_tdata[70:64]));
        compare_field("free_blocks", 32'(want.free_blocks), 32'(m_tdata[77:71]));
      end
    end
  end

  // Receiver: random stall bursts, long ready stretches, none in the calm tail
  initial begin : sink_pacing
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin : run_limit
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] base;
    int          phase;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    calm = 1'b0;
    mismatch_count = 0;
    blk_count = 0;
    bump_ptr = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: zero size, null and unknown frees, overflow, reuse,
    // extreme heap starts and saturated byte count from overlapping blocks
    dir_rows.push_back(ask_typed(ffba_pkg::REQ_ALLOC, 32'd0, 32'd0, 32'd0, ffba_pkg::ST_OK,
                                 32'd0, 7'd1, 7'd0));
    dir_rows.push_back(ask_typed(ffba_pkg::REQ_FREE, 32'd0, 32'd0, 32'd0,
                                 ffba_pkg::ST_NOT_FOUND, 32'd0, 7'd1, 7'd0));
    dir_rows.push_back(heap_row(32'h0000_1000));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'h0000_0100, 32'hFFFF_FFFF));
    dir_rows.push_back(ask_typed(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0,
                                 ffba_pkg::ST_OVERFLOW, 32'h0000_0100, 7'd2, 7'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'h0000_1000));
    dir_rows.push_back(ask_typed(ffba_pkg::REQ_FREE, 32'd0, 32'h0000_1000, 32'd0,
                                 ffba_pkg::ST_NOT_FOUND, 32'd0, 7'd1, 7'd1));
    dir_rows.push_back(ask_typed(ffba_pkg::REQ_FREE, 32'd0, 32'h1234_5678, 32'd0,
                                 ffba_pkg::ST_NOT_FOUND, 32'd0, 7'd1, 7'd1));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'h0000_0080, 32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_FREE, 32'd0, 32'h0000_1000));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'h0000_0200, 32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'd0, 32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_FREE, 32'd0, 32'hFFFF_FFFF));
    dir_rows.push_back(heap_row(32'hFFFF_FFFF));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'd0, 32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'd1, 32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_FREE, 32'd0, 32'hFFFF_FFFF));
    dir_rows.push_back(heap_row(32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0));
    dir_rows.push_back(heap_row(32'h0000_0010));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'h8000_0000, 32'd0));
    dir_rows.push_back(ask(ffba_pkg::REQ_FREE, 32'd0, 32'h0000_0010));
    dir_rows.push_back(ask(ffba_pkg::REQ_ALLOC, 32'h7FFF_FFFF, 32'd0));

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_HEAP_START) begin
        write_heap_start(dir_rows[k].addr);
      end else begin
        maybe_pause();
        put_word(dir_rows[k].req_type, dir_rows[k].size, dir_rows[k].addr, dir_rows[k].typed,
                 dir_rows[k].want);
      end
    end

    // Random phases, each behind a fresh heap_start; the last one runs without idling
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: base = 32'd0;
        1: base = 32'hFFFF_FFFF - $urandom_range(0, 16'hFFFF);
        2: base = $urandom;
        default: base = $urandom_range(1, 16'hFFFF) << 4;
      endcase
      if (phase == PHASES - 1) calm = 1'b1;
      write_heap_start(base);
      repeat (PHASE_WORDS) random_word();
    end
    s_tvalid <= 1'b0;

    // Wait out the remaining results, then a little longer for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
